/* src/bcpd_pkg.sv */
// Shared types and constants of the batched command parameter deframer.
// Depends on nothing; every other file of the block imports it, apart from the stream interfaces.
package bcpd_pkg;

  localparam int unsigned PHASE_W = 3;

  localparam logic [PHASE_W-1:0] PH_BATCH_START = 3'd0;
  localparam logic [PHASE_W-1:0] PH_SET_WIDTH   = 3'd1;
  localparam logic [PHASE_W-1:0] PH_SET_MSG     = 3'd2;
  localparam logic [PHASE_W-1:0] PH_SET_BATCH   = 3'd3;
  localparam logic [PHASE_W-1:0] PH_COMMAND     = 3'd4;
  localparam logic [PHASE_W-1:0] PH_PARAM       = 3'd5;

  localparam logic [1:0] KIND_VALUE  = 2'd0;
  localparam logic [1:0] KIND_ACCEPT = 2'd1;
  localparam logic [1:0] KIND_REJECT = 2'd2;

  localparam logic [2:0] WIDTH_ONE  = 3'd1;
  localparam logic [2:0] WIDTH_TWO  = 3'd2;
  localparam logic [2:0] WIDTH_FOUR = 3'd4;

  localparam logic [2:0] REG_SETUP_MARKER = 3'd0;

  typedef struct packed {
    logic [1:0]         kind;
    logic [7:0]         command;
    logic [7:0]         entry_index;
    logic [7:0]         param_index;
    logic signed [15:0] value;
    logic               batch_end;
  } result_t;

endpackage

/* src/bcpd_stream_if.sv */
// Valid/ready channel interfaces for received bytes and parsed results.
// Depends on nothing.
interface bcpd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface bcpd_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic [7:0]         command;
  logic [7:0]         entry_index;
  logic [7:0]         param_index;
  logic signed [15:0] value;
  logic               batch_end;

  modport source (output valid, output kind, output command, output entry_index,
                  output param_index, output value, output batch_end, input ready);
  modport sink (input valid, input kind, input command, input entry_index,
                input param_index, input value, input batch_end, output ready);
endinterface

/* src/bcpd_cfg_regs.sv */
// APB-style register file holding the setup marker byte.
// Depends on bcpd_pkg.
module bcpd_cfg_regs (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [7:0]  setup_marker
);
  import bcpd_pkg::*;

  logic [7:0] marker_r;
  logic       sel_marker;

  assign sel_marker = (paddr[2] == REG_SETUP_MARKER[2]);
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      marker_r <= 8'd0;
    end else if (psel && penable && pwrite && sel_marker) begin
      marker_r <= pwdata[7:0];
    end
  end

  assign prdata = sel_marker ? {24'd0, marker_r} : 32'd0;
  assign setup_marker = marker_r;

endmodule

/* src/bcpd_parser.sv */
// Frame parser: phase, setup fields, counters and the parameter accumulator.
// Computes the step for one byte combinationally; depends on bcpd_pkg.
module bcpd_parser (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step,
  input  logic [7:0]           rx_byte,
  input  logic [7:0]           setup_marker,
  output logic                 res_vld,
  output bcpd_pkg::result_t    res
);
  import bcpd_pkg::*;

  logic [PHASE_W-1:0] phase_r, phase_nxt;
  logic [2:0]  width_r, width_nxt;
  logic [7:0]  msg_len_r, msg_len_nxt;
  logic [7:0]  batch_len_r, batch_len_nxt;
  logic [7:0]  entry_cnt_r, entry_cnt_nxt;
  logic [7:0]  param_cnt_r, param_cnt_nxt;
  logic [1:0]  byte_cnt_r, byte_cnt_nxt;
  logic [15:0] acc_r, acc_nxt;
  logic [7:0]  cmd_r, cmd_nxt;

  logic [15:0] acc_new;
  logic [2:0]  byte_cnt_inc;
  logic [7:0]  param_inc;
  logic [7:0]  entry_inc;
  logic        last_param;
  logic        last_entry;

  assign acc_new      = (byte_cnt_r == 2'd0) ? {8'd0, rx_byte} : {acc_r[7:0], rx_byte};
  assign byte_cnt_inc = {1'b0, byte_cnt_r} + 3'd1;
  assign param_inc    = param_cnt_r + 8'd1;
  assign entry_inc    = entry_cnt_r + 8'd1;
  assign last_param   = (param_inc >= msg_len_r);
  assign last_entry   = (entry_inc >= batch_len_r);

  always_comb begin
    phase_nxt     = phase_r;
    width_nxt     = width_r;
    msg_len_nxt   = msg_len_r;
    batch_len_nxt = batch_len_r;
    entry_cnt_nxt = entry_cnt_r;
    param_cnt_nxt = param_cnt_r;
    byte_cnt_nxt  = byte_cnt_r;
    acc_nxt       = acc_r;
    cmd_nxt       = cmd_r;
    res_vld       = 1'b0;
    res           = '0;
    case (phase_r)
      PH_BATCH_START: begin
        if (rx_byte == setup_marker) begin
          phase_nxt = PH_SET_WIDTH;
        end else begin
          entry_cnt_nxt = 8'd0;
          param_cnt_nxt = 8'd0;
          byte_cnt_nxt  = 2'd0;
          cmd_nxt       = rx_byte;
          phase_nxt     = PH_PARAM;
        end
      end
      PH_SET_WIDTH: begin
        if (rx_byte == {5'd0, WIDTH_ONE} || rx_byte == {5'd0, WIDTH_TWO} ||
            rx_byte == {5'd0, WIDTH_FOUR}) begin
          width_nxt = rx_byte[2:0];
          phase_nxt = PH_SET_MSG;
        end else begin
          res_vld   = 1'b1;
          res.kind  = KIND_REJECT;
          phase_nxt = PH_BATCH_START;
        end
      end
      PH_SET_MSG: begin
        if (rx_byte != 8'd0) begin
          msg_len_nxt = rx_byte;
          phase_nxt   = PH_SET_BATCH;
        end else begin
          res_vld   = 1'b1;
          res.kind  = KIND_REJECT;
          phase_nxt = PH_BATCH_START;
        end
      end
      PH_SET_BATCH: begin
        res_vld   = 1'b1;
        phase_nxt = PH_BATCH_START;
        if (rx_byte != 8'd0) begin
          batch_len_nxt = rx_byte;
          res.kind      = KIND_ACCEPT;
        end else begin
          res.kind = KIND_REJECT;
        end
      end
      PH_COMMAND: begin
        cmd_nxt       = rx_byte;
        param_cnt_nxt = 8'd0;
        byte_cnt_nxt  = 2'd0;
        phase_nxt     = PH_PARAM;
      end
      default: begin
        acc_nxt = acc_new;
        if (byte_cnt_inc < width_r) begin
          byte_cnt_nxt = byte_cnt_inc[1:0];
        end else begin
          byte_cnt_nxt    = 2'd0;
          res_vld         = 1'b1;
          res.kind        = KIND_VALUE;
          res.command     = cmd_r;
          res.entry_index = entry_cnt_r;
          res.param_index = param_cnt_r;
          res.value       = acc_new;
          res.batch_end   = last_param && last_entry;
          if (!last_param) begin
            param_cnt_nxt = param_inc;
          end else if (!last_entry) begin
            entry_cnt_nxt = entry_inc;
            param_cnt_nxt = 8'd0;
            phase_nxt     = PH_COMMAND;
          end else begin
            entry_cnt_nxt = 8'd0;
            param_cnt_nxt = 8'd0;
            phase_nxt     = PH_BATCH_START;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_BATCH_START;
      width_r     <= WIDTH_TWO;
      msg_len_r   <= 8'd1;
      batch_len_r <= 8'd1;
      entry_cnt_r <= 8'd0;
      param_cnt_r <= 8'd0;
      byte_cnt_r  <= 2'd0;
      acc_r       <= 16'd0;
      cmd_r       <= 8'd0;
    end else if (step) begin
      phase_r     <= phase_nxt;
      width_r     <= width_nxt;
      msg_len_r   <= msg_len_nxt;
      batch_len_r <= batch_len_nxt;
      entry_cnt_r <= entry_cnt_nxt;
      param_cnt_r <= param_cnt_nxt;
      byte_cnt_r  <= byte_cnt_nxt;
      acc_r       <= acc_nxt;
      cmd_r       <= cmd_nxt;
    end
  end

endmodule

/* src/bcpd_out_reg.sv */
// Result register of the deframer, holding one result until it is taken.
// Depends on bcpd_pkg.
module bcpd_out_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  bcpd_pkg::result_t res,
  input  logic              out_ready,
  output logic              free,
  output logic              out_valid,
  output bcpd_pkg::result_t out_res
);
  import bcpd_pkg::*;

  logic    valid_r;
  result_t res_r;

  assign free = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (free) begin
      valid_r <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && free) begin
      res_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

/* src/batched_command_param_deframer_top.sv */
// Top level of the batched command parameter deframer.
// Depends on bcpd_pkg, the stream interfaces, bcpd_cfg_regs, bcpd_parser and bcpd_out_reg.
// The block takes one received byte per clock cycle unless a byte stalls on the result
// register, and returns at most one result per byte. A byte first lands in the input
// register; the parser then updates its phase, counters and accumulator from it and, when
// a parameter or setup completes or a setup byte is rejected, writes the result register.
// Bytes that produce no result never wait on the result channel; a byte that produces a
// result waits only while the result register still holds an untaken result.
module batched_command_param_deframer_top (
  input  logic        clk,
  input  logic        rst_n,
  bcpd_in_if.sink     in_ch,
  bcpd_out_if.source  out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import bcpd_pkg::*;

  logic       in_vld_r;
  logic [7:0] in_byte_r;
  logic [7:0] setup_marker;
  logic       res_vld;
  result_t    res;
  logic       out_free;
  logic       step;
  result_t    out_res;

  bcpd_cfg_regs u_cfg (
    .clk          (clk),
    .rst_n        (rst_n),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .setup_marker (setup_marker)
  );

  assign step = in_vld_r && (!res_vld || out_free);
  assign in_ch.ready = !in_vld_r || step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      in_byte_r <= in_ch.rx_byte;
    end
  end

  bcpd_parser u_parser (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (step),
    .rx_byte      (in_byte_r),
    .setup_marker (setup_marker),
    .res_vld      (res_vld),
    .res          (res)
  );

  bcpd_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (step && res_vld),
    .res       (res),
    .out_ready (out_ch.ready),
    .free      (out_free),
    .out_valid (out_ch.valid),
    .out_res   (out_res)
  );

  assign out_ch.kind        = out_res.kind;
  assign out_ch.command     = out_res.command;
  assign out_ch.entry_index = out_res.entry_index;
  assign out_ch.param_index = out_res.param_index;
  assign out_ch.value       = out_res.value;
  assign out_ch.batch_end   = out_res.batch_end;

endmodule

/* src/bcpd_checker.sv */
// Port-level assertions for the deframer and the bind that attaches them.
// Depends on bcpd_pkg and batched_command_param_deframer_top.
module bcpd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_kind,
  input logic [7:0]  out_command,
  input logic [7:0]  out_entry_index,
  input logic [7:0]  out_param_index,
  input logic [15:0] out_value,
  input logic        out_batch_end,
  input logic        psel,
  input logic        penable,
  input logic        pwrite,
  input logic [2:0]  paddr,
  input logic [31:0] pwdata,
  input logic [31:0] prdata
);
  import bcpd_pkg::*;

  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("Result valid after reset.");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_value) &&
      $stable(out_command) && $stable(out_batch_end))
    else $error("Stalled result changed.");

  a_setup_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != KIND_VALUE |-> out_command == 8'd0 &&
      out_entry_index == 8'd0 && out_param_index == 8'd0 && out_value == 16'd0 &&
      !out_batch_end)
    else $error("Setup result carries nonzero fields.");

  a_marker_readback: assert property (@(posedge clk) disable iff (!rst_n)
    psel && penable && pwrite && paddr[2] == REG_SETUP_MARKER[2] ##1 paddr[2] == 1'b0
      |-> prdata == {24'd0, $past(pwdata[7:0])})
    else $error("Setup marker readback mismatch.");

endmodule

bind batched_command_param_deframer_top bcpd_checker u_bcpd_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_kind        (out_ch.kind),
  .out_command     (out_ch.command),
  .out_entry_index (out_ch.entry_index),
  .out_param_index (out_ch.param_index),
  .out_value       (out_ch.value),
  .out_batch_end   (out_ch.batch_end),
  .psel            (psel),
  .penable         (penable),
  .pwrite          (pwrite),
  .paddr           (paddr),
  .pwdata          (pwdata),
  .prdata          (prdata)
);
